// ----- hw/rtl/array_list_insert_delete_locate_macros.svh -----
// assertion helpers for the ordered list block
`ifndef ARRAY_LIST_INSERT_DELETE_LOCATE_MACROS_SVH
`define ARRAY_LIST_INSERT_DELETE_LOCATE_MACROS_SVH

// property that must hold at every clock edge outside reset
`define ALIDL_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// property that must hold in the cycle after its trigger
`define ALIDL_ASSERT_NEXT(label, clk, rst, trig, prop, msg) \
   `ALIDL_ASSERT(label, clk, rst, (trig) |=> (prop), msg)

`endif

// ----- hw/rtl/alidl_pkg.sv -----
// ----------------------------------------------------------------------------
// alidl_pkg
// Shared types and constants of the ordered list block: request codes, field
// widths and the control word that the top level hands to every cell.
// ----------------------------------------------------------------------------
package alidl_pkg;

   // default number of list entries
   localparam int DEPTH_DEFAULT = 64;

   // width of one stored value
   localparam int VALUE_W = 32;

   // width of the request code
   localparam int REQ_W = 2;

   // request codes
   typedef enum logic [REQ_W-1:0] {
      REQ_INSERT = 2'd0,
      REQ_DELETE = 2'd1,
      REQ_LOCATE = 2'd2
   } req_code_type;

   // control word broadcast along the cell row
   typedef struct packed {
      logic                      ins_en;
      logic                      del_en;
      logic signed [VALUE_W-1:0] item;
   } cell_ctrl_type;

endpackage

// ----- hw/rtl/alidl_cell.sv -----
// ----------------------------------------------------------------------------
// alidl_cell
// One list entry. Compares its value against the request, passes the
// match-seen flag to the next cell and takes its left or right neighbor's
// value, or the new item, when an insert or a delete moves the entries.
// ----------------------------------------------------------------------------
module alidl_cell #(
   parameter int CNT_W = 7,
   parameter int INDEX = 0
) (
   input  logic                                  clock,
   input  alidl_pkg::cell_ctrl_type              ctrl,
   input  logic [CNT_W-1:0]                      req_position,
   input  logic [CNT_W-1:0]                      entry_count,
   input  logic signed [alidl_pkg::VALUE_W-1:0]  left_value,
   input  logic signed [alidl_pkg::VALUE_W-1:0]  right_value,
   input  logic                                  hit_in,
   output logic signed [alidl_pkg::VALUE_W-1:0]  value,
   output logic                                  hit_out,
   output logic [CNT_W-1:0]                      found_pos
);

   localparam logic [CNT_W-1:0] IDX       = CNT_W'(INDEX);
   localparam logic [CNT_W-1:0] ONE_BASED = CNT_W'(INDEX + 1);

   logic signed [alidl_pkg::VALUE_W-1:0] value_ff;
   logic signed [alidl_pkg::VALUE_W-1:0] value_in;
   logic                                 cell_valid;
   logic                                 match;

   // compare against the request and extend the match chain
   assign cell_valid = (IDX < entry_count);
   assign match      = cell_valid && (value_ff == ctrl.item);
   assign hit_out    = hit_in | match;
   assign found_pos  = (match && !hit_in) ? ONE_BASED : '0;
   assign value      = value_ff;

   // next value: new item, shift up on insert, shift down on delete
   always_comb begin
      value_in = value_ff;
      if (ctrl.ins_en) begin
         if (req_position == ONE_BASED) begin
            value_in = ctrl.item;
         end else if (req_position <= IDX) begin
            value_in = left_value;
         end
      end else if (ctrl.del_en && hit_out) begin
         value_in = right_value;
      end
   end

   // entry storage, no reset: read only below the count
   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

endmodule

// ----- hw/rtl/array_list_insert_delete_locate.sv -----
// ----------------------------------------------------------------------------
// array_list_insert_delete_locate
// Bounded ordered list of signed 32-bit values in a row of register cells.
// ----------------------------------------------------------------------------
// Each request is transferred, every cell compares and shifts at the same
// edge, and the result sits in the output register in the next cycle. A new
// request is taken every cycle as long as the result side does not stall; a
// stalled result holds the input off for as long. The rate is set by the cell
// row, where all entries compare and move in parallel, with the first-match
// flag rippling from cell to cell. After reset the list is empty at once;
// entries are never cleared, only entries below the count are read.
module array_list_insert_delete_locate #(
   parameter int DEPTH = alidl_pkg::DEPTH_DEFAULT,
   parameter int CNT_W = $clog2(DEPTH + 1)
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [alidl_pkg::REQ_W-1:0]           req_type,
   input  logic signed [alidl_pkg::VALUE_W-1:0]  req_item_value,
   input  logic [CNT_W-1:0]                      req_position,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic                                  rsp_ok,
   output logic [CNT_W-1:0]                      rsp_found_position,
   output logic [CNT_W-1:0]                      rsp_list_length
);

   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

   logic [CNT_W-1:0]                     count_ff;
   logic [CNT_W-1:0]                     count_in;
   logic                                 rsp_valid_ff;
   logic                                 rsp_valid_in;
   logic                                 rsp_ok_ff;
   logic                                 rsp_ok_in;
   logic [CNT_W-1:0]                     rsp_found_ff;
   logic [CNT_W-1:0]                     rsp_found_in;
   logic [CNT_W-1:0]                     rsp_length_ff;
   logic [CNT_W-1:0]                     rsp_length_in;

   logic                                 accept;
   logic                                 is_insert;
   logic                                 is_delete;
   logic                                 is_locate;
   logic                                 ins_ok;
   logic                                 del_ok;
   logic                                 any_hit;
   logic [CNT_W-1:0]                     found_any;
   alidl_pkg::cell_ctrl_type             ctrl;

   logic signed [alidl_pkg::VALUE_W-1:0] cell_value [DEPTH];
   logic                                 hit_chain  [DEPTH+1];
   logic [CNT_W-1:0]                     cell_found [DEPTH];

   // request decode and legality
   assign accept    = req_valid && !req_stall;
   assign is_insert = (req_type == alidl_pkg::REQ_INSERT);
   assign is_delete = (req_type == alidl_pkg::REQ_DELETE);
   assign is_locate = (req_type == alidl_pkg::REQ_LOCATE);
   assign ins_ok    = is_insert && (count_ff < DEPTH_CNT) && (req_position != '0)
                      && ({1'b0, req_position} <= ({1'b0, count_ff} + 1'b1));
   assign any_hit   = hit_chain[DEPTH];
   assign del_ok    = is_delete && any_hit;

   // control word for the cell row
   always_comb begin
      ctrl.ins_en = accept && ins_ok;
      ctrl.del_en = accept && del_ok;
      ctrl.item   = req_item_value;
   end

   // row of cells, match flag passed left to right
   assign hit_chain[0] = 1'b0;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic signed [alidl_pkg::VALUE_W-1:0] left_value;
      logic signed [alidl_pkg::VALUE_W-1:0] right_value;

      if (i == 0) begin : g_first
         assign left_value = req_item_value;
      end else begin : g_mid_left
         assign left_value = cell_value[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign right_value = cell_value[i];
      end else begin : g_mid_right
         assign right_value = cell_value[i+1];
      end

      alidl_cell #(
         .CNT_W (CNT_W),
         .INDEX (i)
      ) u_cell (
         .clock        (clock),
         .ctrl         (ctrl),
         .req_position (req_position),
         .entry_count  (count_ff),
         .left_value   (left_value),
         .right_value  (right_value),
         .hit_in       (hit_chain[i]),
         .value        (cell_value[i]),
         .hit_out      (hit_chain[i+1]),
         .found_pos    (cell_found[i])
      );
   end

   // at most one cell reports a first match, so an or merges them
   always_comb begin
      found_any = '0;
      for (int i = 0; i < DEPTH; i++) begin
         found_any = found_any | cell_found[i];
      end
   end

   // next count
   always_comb begin
      count_in = count_ff;
      if (ctrl.ins_en) begin
         count_in = count_ff + 1'b1;
      end else if (ctrl.del_en) begin
         count_in = count_ff - 1'b1;
      end
   end

   // output register loads on transfer, empties when taken
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_ok_in     = rsp_ok_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_length_in = rsp_length_ff;
      if (accept) begin
         rsp_valid_in  = 1'b1;
         rsp_ok_in     = ins_ok || del_ok || (is_locate && any_hit);
         rsp_found_in  = is_locate ? found_any : '0;
         rsp_length_in = count_in;
      end else if (!rsp_stall) begin
         rsp_valid_in  = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      rsp_ok_ff     <= rsp_ok_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_length_ff <= rsp_length_in;
   end

   // ports
   assign req_stall          = rsp_valid_ff && rsp_stall;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_ok             = rsp_ok_ff;
   assign rsp_found_position = rsp_found_ff;
   assign rsp_list_length    = rsp_length_ff;

endmodule

// ----- hw/rtl/alidl_checker.sv -----
// ----------------------------------------------------------------------------
// alidl_checker
// Port-level checks of the ordered list block: request and result hold under
// stall and consistency of the reported position, status and length.
// ----------------------------------------------------------------------------
`include "array_list_insert_delete_locate_macros.svh"

module alidl_checker #(
   parameter int DEPTH = alidl_pkg::DEPTH_DEFAULT,
   parameter int CNT_W = $clog2(DEPTH + 1)
) (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  req_valid,
   input logic                                  req_stall,
   input logic [alidl_pkg::REQ_W-1:0]           req_type,
   input logic signed [alidl_pkg::VALUE_W-1:0]  req_item_value,
   input logic [CNT_W-1:0]                      req_position,
   input logic                                  rsp_valid,
   input logic                                  rsp_stall,
   input logic                                  rsp_ok,
   input logic [CNT_W-1:0]                      rsp_found_position,
   input logic [CNT_W-1:0]                      rsp_list_length
);

   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

   // a stalled request stays and holds its payload
   `ALIDL_ASSERT_NEXT(a_req_hold, clock, reset, req_valid && req_stall, req_valid && $stable(req_type) && $stable(req_item_value) && $stable(req_position), "stalled request changed")

   // a stalled result stays and holds its payload
   `ALIDL_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_ok) && $stable(rsp_found_position) && $stable(rsp_list_length), "stalled result changed")

   // the reported length never exceeds the capacity
   `ALIDL_ASSERT(a_len_bound, clock, reset, rsp_valid |-> (rsp_list_length <= DEPTH_CNT), "list length above capacity")

   // a failed request reports no position
   `ALIDL_ASSERT(a_fail_nopos, clock, reset, (rsp_valid && !rsp_ok) |-> (rsp_found_position == '0), "position reported on failure")

   // a reported position is a success and lies inside the list
   `ALIDL_ASSERT(a_pos_inside, clock, reset, (rsp_valid && (rsp_found_position != '0)) |-> (rsp_ok && (rsp_found_position <= rsp_list_length)), "found position outside list")

endmodule

bind array_list_insert_delete_locate alidl_checker #(
   .DEPTH (DEPTH),
   .CNT_W (CNT_W)
) u_alidl_checker (.*);

// ----- tb/array_list_insert_delete_locate_checker.sv -----
// ----------------------------------------------------------------------------
// array_list_insert_delete_locate_checker
// Watches both channels of the ordered list block. Each request transfer
// updates a shadow copy of the list and queues the result it must produce.
// Each result transfer is compared field by field with the oldest queued one.
// The shadow list and its length are handed back so that stimulus can aim
// deletes and locates at values that are really held.
// ----------------------------------------------------------------------------
module array_list_insert_delete_locate_checker #(
   parameter int LIST_DEPTH = alidl_pkg::DEPTH_DEFAULT,
   parameter int POS_W      = $clog2(LIST_DEPTH + 1)
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          req_valid,
   input  logic                                          req_stall,
   input  logic [alidl_pkg::REQ_W-1:0]                   req_type,
   input  logic signed [alidl_pkg::VALUE_W-1:0]          req_item_value,
   input  logic [POS_W-1:0]                              req_position,
   input  logic                                          rsp_valid,
   input  logic                                          rsp_stall,
   input  logic                                          rsp_ok,
   input  logic [POS_W-1:0]                              rsp_found_position,
   input  logic [POS_W-1:0]                              rsp_list_length,
   output int                                            fail_count,
   output int                                            pending,
   output int                                            known_length,
   output logic [LIST_DEPTH-1:0][alidl_pkg::VALUE_W-1:0] list_view
);
   timeunit 1ns;
   timeprecision 1ps;

   import alidl_pkg::*;

   typedef struct {
      logic             ok;
      logic [POS_W-1:0] found;
      logic [POS_W-1:0] length;
   } list_answer_type;

   // shadow list: entries below list_count are the live ones
   logic [LIST_DEPTH-1:0][VALUE_W-1:0] shadow_list;
   int                                 list_count;
   list_answer_type                    awaited_answers[$];
   list_answer_type                    oldest;
   int                                 mismatches = 0;

   initial begin
      pending      = 0;
      known_length = 0;
      list_view    = '0;
      list_count   = 0;
      shadow_list  = '0;
   end

   assign fail_count = mismatches;

   // one line per mismatch, printing capped to keep the log short
   task automatic report_mismatch(input string msg);
      begin
         if (mismatches < 100)
            $display("mismatch at %0t ns: %s", $time, msg);
         mismatches++;
      end
   endtask

   // index of the first live entry equal to v, or -1
   function automatic int first_equal(input logic [VALUE_W-1:0] v);
      int i;
      begin
         for (i = 0; i < list_count; i++)
            if (shadow_list[i] == v)
               return i;
         return -1;
      end
   endfunction

   // apply one request to the shadow list and work out its answer
   function automatic list_answer_type apply_list_request(
      input logic [REQ_W-1:0]   kind,
      input logic [VALUE_W-1:0] value,
      input logic [POS_W-1:0]   pos
   );
      list_answer_type answer;
      int              i;
      int              hit;
      begin
         answer.ok    = 1'b0;
         answer.found = '0;
         case (kind)
            REQ_INSERT: begin
               if (list_count < LIST_DEPTH && int'(pos) >= 1 && int'(pos) <= list_count + 1) begin
                  for (i = list_count; i >= int'(pos); i--)
                     shadow_list[i] = shadow_list[i-1];
                  shadow_list[int'(pos)-1] = value;
                  list_count++;
                  answer.ok = 1'b1;
               end
            end
            REQ_DELETE: begin
               hit = first_equal(value);
               if (hit >= 0) begin
                  for (i = hit + 1; i < list_count; i++)
                     shadow_list[i-1] = shadow_list[i];
                  list_count--;
                  answer.ok = 1'b1;
               end
            end
            REQ_LOCATE: begin
               hit = first_equal(value);
               if (hit >= 0) begin
                  answer.found = POS_W'(hit + 1);
                  answer.ok    = 1'b1;
               end
            end
            default: ;
         endcase
         answer.length = POS_W'(list_count);
         return answer;
      end
   endfunction

   // results are matched before requests: a result at this edge is always older
   always @(posedge clock) begin
      if (reset) begin
         list_count = 0;
         awaited_answers.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (awaited_answers.size() == 0) begin
               report_mismatch($sformatf("result with nothing awaited: ok %0d pos %0d len %0d",
                                         rsp_ok, rsp_found_position, rsp_list_length));
            end else begin
               oldest = awaited_answers.pop_front();
               if (rsp_ok !== oldest.ok)
                  report_mismatch($sformatf("ok got %0d expected %0d", rsp_ok, oldest.ok));
               if (rsp_found_position !== oldest.found)
                  report_mismatch($sformatf("found_position got %0d expected %0d",
                                            rsp_found_position, oldest.found));
               if (rsp_list_length !== oldest.length)
                  report_mismatch($sformatf("list_length got %0d expected %0d",
                                            rsp_list_length, oldest.length));
            end
         end
         if (req_valid && !req_stall)
            awaited_answers.push_back(apply_list_request(req_type, req_item_value,
                                                         req_position));
      end
      pending      <= awaited_answers.size();
      known_length <= list_count;
      list_view    <= shadow_list;
   end

endmodule

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the ordered list block. A short directed run walks
// through the edge cases of insert, delete and locate; random phases then grow
// the list and shrink it again under several idle and stall mixes.
// Prediction and comparison live in the checker beside the block.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import alidl_pkg::*;

   localparam int LIST_DEPTH     = DEPTH_DEFAULT;
   localparam int POS_W          = $clog2(LIST_DEPTH + 1);
   localparam int FILL_ITEMS     = 95;
   localparam int DRAIN_ITEMS    = 115;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int SETTLE_CYCLES  = 4;

   // request code that the block leaves unused
   localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

   logic                          clock;
   logic                          reset;
   logic                          req_valid;
   logic                          req_stall;
   logic [REQ_W-1:0]              req_type;
   logic signed [VALUE_W-1:0]     req_item_value;
   logic [POS_W-1:0]              req_position;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   logic                          rsp_ok;
   logic [POS_W-1:0]              rsp_found_position;
   logic [POS_W-1:0]              rsp_list_length;

   int                            fail_count;
   int                            pending;
   int                            known_length;
   logic [LIST_DEPTH-1:0][VALUE_W-1:0] list_view;

   int                            sender_idle_pct = 0;
   int                            stall_pct       = 0;
   int                            quiet_cycles    = 0;
   int                            phase;

   array_list_insert_delete_locate #(
      .DEPTH (LIST_DEPTH)
   ) i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_type           (req_type),
      .req_item_value     (req_item_value),
      .req_position       (req_position),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_ok             (rsp_ok),
      .rsp_found_position (rsp_found_position),
      .rsp_list_length    (rsp_list_length)
   );

   array_list_insert_delete_locate_checker #(
      .LIST_DEPTH (LIST_DEPTH)
   ) i_checker (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_type           (req_type),
      .req_item_value     (req_item_value),
      .req_position       (req_position),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_ok             (rsp_ok),
      .rsp_found_position (rsp_found_position),
      .rsp_list_length    (rsp_list_length),
      .fail_count         (fail_count),
      .pending            (pending),
      .known_length       (known_length),
      .list_view          (list_view)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // result side stalls at random
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("array_list_insert_delete_locate test failed");
            $finish;
         end
      end
   end

   // present one request and hold it until transfer, then maybe go idle
   task automatic send_request(input logic [REQ_W-1:0] kind,
                               input logic signed [VALUE_W-1:0] value,
                               input logic [POS_W-1:0] pos);
      begin
         req_valid      <= 1'b1;
         req_type       <= kind;
         req_item_value <= value;
         req_position   <= pos;
         @(posedge clock);
         while (req_stall)
            @(posedge clock);
         while ($urandom_range(99) < sender_idle_pct) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
   endtask

   // hold off new requests until every awaited result is back
   task automatic wait_all_answered();
      begin
         req_valid <= 1'b0;
         @(posedge clock);
         while (pending != 0)
            @(posedge clock);
      end
   endtask

   // extremes and small values, so duplicates are common
   function automatic logic signed [VALUE_W-1:0] common_value();
      begin
         case ($urandom_range(5))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7fff_ffff;
            2:       return 32'sh0000_0000;
            3:       return -32'sd1;
            default: return $urandom_range(1, 12);
         endcase
      end
   endfunction

   // random request, biased toward growing or shrinking the list
   task automatic send_random_request(input bit growing);
      int                        roll;
      int                        held;
      logic [REQ_W-1:0]          kind;
      logic signed [VALUE_W-1:0] value;
      logic [POS_W-1:0]          pos;
      begin
         roll = $urandom_range(99);
         held = known_length;
         if (growing)
            kind = (roll < 80) ? REQ_INSERT : (roll < 88) ? REQ_DELETE :
                   (roll < 96) ? REQ_LOCATE : REQ_UNUSED;
         else
            kind = (roll < 70) ? REQ_DELETE : (roll < 85) ? REQ_LOCATE :
                   (roll < 96) ? REQ_INSERT : REQ_UNUSED;

         // values: aim at held entries for delete and locate
         roll = $urandom_range(99);
         if (kind == REQ_INSERT)
            value = (roll < 50) ? common_value() : $urandom;
         else if (held > 0 && roll < 70)
            value = list_view[$urandom_range(held - 1)];
         else if (roll < 85)
            value = common_value();
         else
            value = $urandom;

         // positions: mostly in range, some zero, some anywhere
         roll = $urandom_range(99);
         if (kind == REQ_INSERT && roll < 80)
            pos = POS_W'($urandom_range(1, held + 1));
         else if (roll < 90)
            pos = '0;
         else
            pos = POS_W'($urandom_range(0, 127));

         send_request(kind, value, pos);
      end
   endtask

   // stimulus and verdict
   initial begin
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_type       = REQ_INSERT;
      req_item_value = '0;
      req_position   = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: empty list, bad positions, front/middle/end inserts, first match
      send_request(REQ_LOCATE, 32'sd0, 7'd0);
      send_request(REQ_DELETE, 32'sd0, 7'd0);
      send_request(REQ_INSERT, 32'sd5, 7'd0);
      send_request(REQ_INSERT, 32'sd5, 7'd2);
      send_request(REQ_INSERT, 32'sd5, 7'd127);
      send_request(REQ_INSERT, 32'sh7fff_ffff, 7'd1);
      send_request(REQ_INSERT, 32'sh8000_0000, 7'd1);
      send_request(REQ_INSERT, -32'sd1, 7'd3);
      send_request(REQ_INSERT, 32'sd0, 7'd2);
      send_request(REQ_INSERT, 32'sh8000_0000, 7'd5);
      send_request(REQ_LOCATE, 32'sh8000_0000, 7'd127);
      send_request(REQ_LOCATE, -32'sd1, 7'd0);
      send_request(REQ_LOCATE, 32'sd12345, 7'd0);
      send_request(REQ_UNUSED, 32'sh8000_0000, 7'd1);
      send_request(REQ_DELETE, 32'sh8000_0000, 7'd64);
      send_request(REQ_LOCATE, 32'sh8000_0000, 7'd0);
      send_request(REQ_DELETE, 32'sd555, 7'd0);
      send_request(REQ_INSERT, 32'sd7, 7'd64);
      send_request(REQ_INSERT, 32'sd7, 7'd6);
      send_request(REQ_UNUSED, -32'sd1, 7'd127);
      wait_all_answered();

      // random phases under different idle and stall mixes
      for (phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin sender_idle_pct = 0;  stall_pct <= 0;  end
            1: begin sender_idle_pct = 72; stall_pct <= 0;  end
            2: begin sender_idle_pct = 0;  stall_pct <= 72; end
            default: begin sender_idle_pct = 36; stall_pct <= 36; end
         endcase
         repeat (FILL_ITEMS) send_random_request(1'b1);
         repeat (DRAIN_ITEMS) send_random_request(1'b0);
         wait_all_answered();
      end

      stall_pct <= 0;
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending == 0)
         $display("array_list_insert_delete_locate test passed");
      else
         $display("array_list_insert_delete_locate test failed");
      $finish;
   end

endmodule
